[rtl/core/sgi_pkg.sv]
// sgi_pkg: shared types and constants for the segment gap inserter.
// Item structs, controller states, datapath commands and status.
// No dependencies.
package sgi_pkg;

  localparam int SZ_W = 32;                    // segment size/offset width
  localparam logic [SZ_W-1:0] NO_NEXT = '1;    // next_offset value meaning none

  localparam logic [1:0] CFG_AUTO_MODE      = 2'd0;
  localparam logic [1:0] CFG_FIXED_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_FIXED_INSERT   = 2'd2;

  localparam logic       REQ_HEADER = 1'b0;
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_PAD     = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOB = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [SZ_W-1:0] segment_offset;
    logic [SZ_W-1:0] segment_size;
    logic [SZ_W-1:0] next_offset;
    logic [SZ_W-1:0] file_length;
    logic [SZ_W-1:0] prefix_bytes;
    logic [7:0]      data_byte;
  } sgi_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        status;
    logic [7:0]  out_byte;
    logic [31:0] pad_length;
    logic [31:0] insert_point;
    logic [31:0] size_padded;
    logic [31:0] ivl_chosen;
    logic [31:0] event_count;
    logic [31:0] pad_total;
    logic        last;
  } sgi_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_BRANCH, S_LOOP, S_WAIT_E, S_ST_N, S_WAIT_N, S_ST_S,
    S_WAIT_S, S_MUL_S, S_CMP, S_WAIT_F, S_MUL_F, S_CLAMP, S_FIN, S_FIN2,
    S_WAIT_B, S_SUM, S_DPAD
  } sgi_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DATA, OP_PREP, OP_SRCH_INIT, OP_DIV_E, OP_TAKE_E,
    OP_DIV_N, OP_TAKE_N, OP_DIV_S, OP_TAKE_S, OP_MUL_S, OP_CMP, OP_DIV_F,
    OP_TAKE_F, OP_MUL_F, OP_CLAMP, OP_FIN, OP_DIV_B, OP_TAKE_B, OP_SUM, OP_PAD
  } sgi_op_t;

  typedef struct packed {
    sgi_op_t op;
  } sgi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic oob;
    logic plan_en;
    logic use_search;
    logic srch_more;
    logic ev_nz;
  } sgi_stat_t;

endpackage

[rtl/core/sgi_div.sv]
// sgi_div: restoring divider, one quotient bit per cycle.
// Uses sgi_pkg for the operand width.
module sgi_div
  import sgi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SZ_W-1:0] dividend,
  input  logic [SZ_W-1:0] divisor,
  output logic            done,
  output logic [SZ_W-1:0] quo,
  output logic [SZ_W-1:0] rem
);

  localparam int CW = $clog2(SZ_W + 1);

  logic [SZ_W-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [SZ_W:0]   shifted, trial;

  always_comb begin
    shifted  = {rem_r, quo_r[SZ_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(SZ_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[SZ_W]) begin
        rem_nxt = shifted[SZ_W-1:0];
        quo_nxt = {quo_r[SZ_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[SZ_W-1:0];
        quo_nxt = {quo_r[SZ_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

[rtl/core/sgi_oq.sv]
// sgi_oq: four-entry result queue between datapath and output channel.
// Uses sgi_pkg for the result item type.
module sgi_oq
  import sgi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sgi_out_t push_item,
  output logic     room,
  output logic     out_valid,
  input  logic     out_stall,
  output sgi_out_t out_item
);

  sgi_out_t   mem [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_item  = mem[rd_r];
  assign room      = (cnt_r <= 3'd2);

  always_comb begin
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 2'd1;
      if (pop)  rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd4) |-> !push)
    else $error("push into full result queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 3'd1))
    else $error("queue count did not follow push");
`endif

endmodule

[rtl/core/sgi_dp.sv]
// sgi_dp: datapath of the gap inserter: header plan, search, byte stream.
// Uses sgi_pkg and instantiates sgi_div; driven by sgi_ctrl commands.
module sgi_dp
  import sgi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sgi_cmd_t   cmd,
  output sgi_stat_t  stat,
  input  sgi_in_t    in_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic       push,
  output sgi_out_t   push_item
);

  // configuration
  logic            auto_r;
  logic [SZ_W-1:0] fi_r, fis_r;
  // header latch and plan
  logic [SZ_W-1:0] off_r, size_r, nxt_r, flen_r, pre_r;
  logic [SZ_W-1:0] pay_r, spare_r;
  logic            oob_r, plan_en_r, use_search_r;
  // search
  logic [SZ_W-1:0] i_r, e_r, n_r, sz_r;
  logic [2*SZ_W-1:0] prod_r;
  logic [SZ_W-1:0] best_ivl_r, best_ev_r, best_tot_r;
  // segment streaming state
  logic            seg_valid_r;
  logic [SZ_W-1:0] seg_len_r, prefix_r, pos_r, icnt_r, civl_r;
  logic [SZ_W-1:0] base_r, extra_r, evt_r, evd_r;
  logic            pad_pend_r;
  logic [SZ_W-1:0] pad_run_r, pad_pt_r;

  // divider
  logic            div_start, div_done;
  logic [SZ_W-1:0] div_a, div_b, div_q, div_rem;

  sgi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  always_comb begin
    div_start = 1'b0;
    div_a     = pay_r - SZ_W'(1);
    div_b     = i_r;
    case (cmd.op)
      OP_DIV_E: div_start = 1'b1;
      OP_DIV_N: begin
        div_start = 1'b1;
        div_b     = e_r;
      end
      OP_DIV_S: begin
        div_start = 1'b1;
        div_a     = spare_r;
        div_b     = e_r;
      end
      OP_DIV_F: begin
        div_start = 1'b1;
        div_b     = fi_r;
      end
      OP_DIV_B: begin
        div_start = 1'b1;
        div_a     = best_tot_r;
        div_b     = best_ev_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  // header prep
  logic            oob_c, plan_c;
  logic [SZ_W-1:0] pre_c, avail_c, room_c;
  always_comb begin
    room_c  = flen_r - off_r;
    oob_c   = (off_r > flen_r) || (size_r > room_c);
    pre_c   = (pre_r > size_r) ? size_r : pre_r;
    avail_c = room_c;
    if (nxt_r != NO_NEXT) begin
      if (nxt_r <= off_r) avail_c = '0;
      else if ((nxt_r - off_r) < room_c) avail_c = nxt_r - off_r;
    end
    plan_c = (size_r != pre_c) && (avail_c > size_r);
  end

  // byte stream
  logic            byte_ok, hit, fire, ev_go;
  logic [SZ_W-1:0] pos_n, cnt_n, run;
  always_comb begin
    byte_ok = seg_valid_r && (pos_r < seg_len_r);
    pos_n   = pos_r + SZ_W'(1);
    cnt_n   = icnt_r + SZ_W'(1);
    hit     = (pos_n > prefix_r) && (civl_r != '0);
    fire    = hit && (cnt_n >= civl_r);
    ev_go   = fire && (pos_n < seg_len_r) && (evd_r < evt_r);
    run     = base_r + SZ_W'(evd_r < extra_r);
  end

  logic [SZ_W-1:0] t_c;
  assign t_c = prod_r[SZ_W-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        off_r  <= in_item.segment_offset;
        size_r <= in_item.segment_size;
        nxt_r  <= in_item.next_offset;
        flen_r <= in_item.file_length;
        pre_r  <= in_item.prefix_bytes;
      end
      OP_PREP: begin
        oob_r        <= oob_c;
        plan_en_r    <= plan_c && !oob_c;
        use_search_r <= auto_r || (fi_r == '0) || (fis_r == '0);
        pay_r        <= size_r - pre_c;
        spare_r      <= avail_c - size_r;
      end
      OP_SRCH_INIT: i_r <= SZ_W'(1);
      OP_TAKE_E:    e_r <= div_q;
      OP_TAKE_N:    n_r <= div_q + SZ_W'(1);
      OP_TAKE_S:    sz_r <= div_q;
      OP_MUL_S:     prod_r <= sz_r * e_r;
      OP_CMP:       i_r <= n_r;
      OP_MUL_F:     prod_r <= best_ev_r * fis_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r      <= 1'b1;
      fi_r        <= '0;
      fis_r       <= '0;
      seg_valid_r <= 1'b0;
      seg_len_r   <= '0;
      prefix_r    <= '0;
      pos_r       <= '0;
      icnt_r      <= '0;
      civl_r      <= '0;
      base_r      <= '0;
      extra_r     <= '0;
      evt_r       <= '0;
      evd_r       <= '0;
      pad_pend_r  <= 1'b0;
      pad_run_r   <= '0;
      pad_pt_r    <= '0;
      best_ivl_r  <= '0;
      best_ev_r   <= '0;
      best_tot_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_AUTO_MODE:      auto_r <= cfg_wdata[0];
          CFG_FIXED_INTERVAL: fi_r   <= cfg_wdata;
          CFG_FIXED_INSERT:   fis_r  <= cfg_wdata;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          seg_valid_r <= 1'b0;
          seg_len_r   <= '0;
          prefix_r    <= '0;
          pos_r       <= '0;
          icnt_r      <= '0;
          civl_r      <= '0;
          base_r      <= '0;
          extra_r     <= '0;
          evt_r       <= '0;
          evd_r       <= '0;
          pad_pend_r  <= 1'b0;
          best_ivl_r  <= '0;
          best_ev_r   <= '0;
          best_tot_r  <= '0;
        end
        OP_PREP: begin
          seg_valid_r <= !oob_c;
          seg_len_r   <= oob_c ? '0 : size_r;
          prefix_r    <= oob_c ? '0 : pre_c;
        end
        OP_CMP: begin
          if ((sz_r != '0) && ((t_c > best_tot_r) ||
              ((t_c == best_tot_r) && (e_r > best_ev_r)))) begin
            best_ivl_r <= i_r;
            best_ev_r  <= e_r;
            best_tot_r <= t_c;
          end
        end
        OP_TAKE_F: begin
          best_ivl_r <= fi_r;
          best_ev_r  <= div_q;
        end
        OP_CLAMP: begin
          best_tot_r <= (prod_r > {{SZ_W{1'b0}}, spare_r}) ? spare_r : t_c;
        end
        OP_FIN: begin
          if ((best_ivl_r == '0) || (best_ev_r == '0) || (best_tot_r == '0)) begin
            best_ivl_r <= '0;
            best_ev_r  <= '0;
            best_tot_r <= '0;
          end
        end
        OP_TAKE_B: begin
          base_r  <= div_q;
          extra_r <= div_rem;
          civl_r  <= best_ivl_r;
          evt_r   <= best_ev_r;
        end
        OP_DATA: begin
          // a zero-length run still uses up its event but emits nothing
          pad_pend_r <= byte_ok && ev_go && (run != '0);
          if (byte_ok) begin
            pos_r <= pos_n;
            if (hit) icnt_r <= fire ? '0 : cnt_n;
            if (ev_go) begin
              evd_r      <= evd_r + SZ_W'(1);
              pad_run_r  <= run;
              pad_pt_r   <= pos_n;
            end
          end
        end
        OP_PAD: pad_pend_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    case (cmd.op)
      OP_DATA: begin
        push                  = byte_ok;
        push_item.result_kind = KIND_BYTE;
        push_item.out_byte    = in_item.data_byte;
        push_item.last        = (pos_n == seg_len_r);
      end
      OP_PAD: begin
        push                   = pad_pend_r;
        push_item.result_kind  = KIND_PAD;
        push_item.pad_length   = pad_run_r;
        push_item.insert_point = pad_pt_r;
      end
      OP_SUM: begin
        push                  = 1'b1;
        push_item.result_kind = KIND_SUMMARY;
        if (oob_r) begin
          push_item.status      = ST_OOB;
          push_item.size_padded = size_r;
          push_item.last        = 1'b1;
        end else begin
          push_item.status      = ST_OK;
          push_item.size_padded = size_r + best_tot_r;
          push_item.ivl_chosen  = best_ivl_r;
          push_item.event_count = best_ev_r;
          push_item.pad_total   = best_tot_r;
          push_item.last        = (size_r == '0);
        end
      end
      default: push = 1'b0;
    endcase
  end

  assign stat.div_done   = div_done;
  assign stat.oob        = oob_r;
  assign stat.plan_en    = plan_en_r;
  assign stat.use_search = use_search_r;
  assign stat.srch_more  = (i_r < pay_r);
  assign stat.ev_nz      = (best_ev_r != '0);

`ifndef SYNTH
  a_evd_bound: assert property (@(posedge clk) disable iff (!rst_n) evd_r <= evt_r)
    else $error("more pad events than planned");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= seg_len_r)
    else $error("byte position past segment end");
  a_pad_nz: assert property (@(posedge clk) disable iff (!rst_n)
    pad_pend_r |-> (pad_run_r != '0))
    else $error("zero-length pad run pending");
`endif

endmodule

[rtl/core/sgi_ctrl.sv]
// sgi_ctrl: sequencer of the gap inserter; issues datapath commands.
// Uses sgi_pkg for states, commands and status.
module sgi_ctrl
  import sgi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  input  logic      room,
  input  sgi_stat_t stat,
  output logic      in_stall,
  output sgi_cmd_t  cmd
);

  sgi_state_t state_r, state_nxt;
  logic       acc;

  assign in_stall = !((state_r == S_IDLE) && room);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (acc) state_nxt = (in_req_type == REQ_HEADER) ? S_PREP : S_DPAD;
      S_PREP:   state_nxt = S_BRANCH;
      S_BRANCH: begin
        if (stat.oob)             state_nxt = S_SUM;
        else if (!stat.plan_en)   state_nxt = S_FIN;
        else if (stat.use_search) state_nxt = S_LOOP;
        else                      state_nxt = S_WAIT_F;
      end
      S_LOOP:   state_nxt = stat.srch_more ? S_WAIT_E : S_FIN;
      S_WAIT_E: if (stat.div_done) state_nxt = S_ST_N;
      S_ST_N:   state_nxt = S_WAIT_N;
      S_WAIT_N: if (stat.div_done) state_nxt = S_ST_S;
      S_ST_S:   state_nxt = S_WAIT_S;
      S_WAIT_S: if (stat.div_done) state_nxt = S_MUL_S;
      S_MUL_S:  state_nxt = S_CMP;
      S_CMP:    state_nxt = S_LOOP;
      S_WAIT_F: if (stat.div_done) state_nxt = S_MUL_F;
      S_MUL_F:  state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_FIN;
      S_FIN:    state_nxt = S_FIN2;
      S_FIN2:   state_nxt = stat.ev_nz ? S_WAIT_B : S_SUM;
      S_WAIT_B: if (stat.div_done) state_nxt = S_SUM;
      S_SUM:    state_nxt = S_IDLE;
      S_DPAD:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:   if (acc) cmd.op = (in_req_type == REQ_HEADER) ? OP_LOAD : OP_DATA;
      S_PREP:   cmd.op = OP_PREP;
      S_BRANCH: begin
        if (!stat.oob && stat.plan_en)
          cmd.op = stat.use_search ? OP_SRCH_INIT : OP_DIV_F;
      end
      S_LOOP:   if (stat.srch_more) cmd.op = OP_DIV_E;
      S_WAIT_E: if (stat.div_done) cmd.op = OP_TAKE_E;
      S_ST_N:   cmd.op = OP_DIV_N;
      S_WAIT_N: if (stat.div_done) cmd.op = OP_TAKE_N;
      S_ST_S:   cmd.op = OP_DIV_S;
      S_WAIT_S: if (stat.div_done) cmd.op = OP_TAKE_S;
      S_MUL_S:  cmd.op = OP_MUL_S;
      S_CMP:    cmd.op = OP_CMP;
      S_WAIT_F: if (stat.div_done) cmd.op = OP_TAKE_F;
      S_MUL_F:  cmd.op = OP_MUL_F;
      S_CLAMP:  cmd.op = OP_CLAMP;
      S_FIN:    cmd.op = OP_FIN;
      S_FIN2:   if (stat.ev_nz) cmd.op = OP_DIV_B;
      S_WAIT_B: if (stat.div_done) cmd.op = OP_TAKE_B;
      S_SUM:    cmd.op = OP_SUM;
      S_DPAD:   cmd.op = OP_PAD;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTH
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (state_r == S_IDLE))
    else $error("item accepted outside idle");
  a_hdr_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_HEADER)) |=> (state_r == S_PREP))
    else $error("header did not start planning");
  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |=> (state_r == S_IDLE))
    else $error("summary not followed by idle");
`endif

endmodule

[rtl/core/segment_gap_inserter.sv]
// segment_gap_inserter: top level of the segment padding planner/streamer.
// Uses sgi_pkg; instantiates sgi_ctrl, sgi_dp and sgi_oq.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------
//   in      | in  | in_valid / in_stall    | in_item  (sgi_in_t)
//   out     | out | out_valid / out_stall  | out_item (sgi_out_t)
//   cfg     | in  | cfg_we (no wait)       | cfg_idx, cfg_wdata
//
// A data item gives its byte result in idle, then an optional pad run in S_DPAD.
// A header runs its plan on the one-bit-per-cycle divider; the interval
// search needs three divides per distinct event count, about
// 2*sqrt(payload) rounds, plus a final tot/ev divide.
// Reset: synchronous, active low; auto_mode comes up 1, all segment state 0.
// Stalls: results wait in a 4-entry queue; an item is accepted in idle
// while the queue has room for two, so out_stall only stalls input when
// that queue backs up.
module segment_gap_inserter
  import sgi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sgi_in_t     in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output sgi_out_t    out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  sgi_cmd_t  cmd;
  sgi_stat_t stat;
  logic      room;
  logic      push;
  sgi_out_t  push_item;

  // sequencer: one item at a time
  sgi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .room        (room),
    .stat        (stat),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  // planning arithmetic, shared divider, byte counters
  sgi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_item (push_item)
  );

  // result queue decouples output stalls from the sequencer
  sgi_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("pushed result item not offered");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> in_stall)
    else $error("input taken with result queue short of space");
  a_sum_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_item.result_kind == KIND_PAD)) |-> (push_item.pad_length != '0))
    else $error("empty pad run pushed");
`endif

endmodule
